// ----- rtl/rspp_pkg.sv -----
// Shared constants, codes and defaults for the stereo point projection core.
package rspp_pkg;

  // Default word format: signed Q16.16 in 32 bits.
  localparam int DEF_DATA_WIDTH    = 32;
  localparam int DEF_FRACTION_BITS = 16;

  // Configuration registers are 31 bits wide, unsigned.
  localparam int CFG_REG_WIDTH   = 31;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH  = 32;

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DEPTH    = 8'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_DEPTH    = 8'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_WIDTH  = 8'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IMAGE_HEIGHT = 8'd3;

  // Register reset values.
  localparam logic [CFG_REG_WIDTH-1:0] RST_MIN_DEPTH    = 31'd0;
  localparam logic [CFG_REG_WIDTH-1:0] RST_MAX_DEPTH    = 31'd655360;
  localparam logic [CFG_REG_WIDTH-1:0] RST_IMAGE_WIDTH  = 31'd41943040;
  localparam logic [CFG_REG_WIDTH-1:0] RST_IMAGE_HEIGHT = 31'd31457280;

  // Coefficient table layout.
  localparam int COEF_INDEX_WIDTH = 5;
  localparam int POSE_ENTRIES     = 12;
  localparam int PROJ_ENTRIES     = 16;
  localparam logic [COEF_INDEX_WIDTH-1:0] POSE_BASE = 5'd0;
  localparam logic [COEF_INDEX_WIDTH-1:0] PROJ_BASE = 5'd12;
  localparam logic [COEF_INDEX_WIDTH-1:0] PROJ_END  = 5'd28;

  // Item operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_DEPTH_REJECT = 2'd1,
    ST_OUT_OF_IMAGE = 2'd2
  } status_e;

endpackage

// ----- rtl/rectified_stereo_point_projection_core.sv -----
// Top level of the rectified stereo point projection core.
// A project transaction leaves after stages 0 to 5, the divider lanes and the output register;
// the lanes resolve DATA_WIDTH + FRACTION_BITS quotient bits, one per stage (default Q16.16).
// Throughput: one item per cycle; the whole pipeline advances together and holds on a stall.
// Load transactions produce no result and take effect in program order.
// Reset (asynchronous, active low) clears all valid bits, both coefficient tables and
// restores the configuration registers to their defaults.
module rectified_stereo_point_projection_core
  import rspp_pkg::*;
#(
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  localparam int IN_BITS      = COEF_INDEX_WIDTH + 4 * DATA_WIDTH,
  localparam int IN_TW        = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TW       = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata, lowest bit up: coef_index, coef_value, point_x, point_y, point_z, zero pad.
  input  logic [IN_TW-1:0]           s_axis_tdata,
  // tuser: operation.
  input  logic                       s_axis_tuser,
  // Result stream.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // tdata, lowest bit up: image_u, image_v, disparity, zero pad.
  output logic [OUT_TW-1:0]          m_axis_tdata,
  // tuser: status.
  output logic [1:0]                 m_axis_tuser,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int S  = W + F;
  localparam int CW = ((W > CFG_REG_WIDTH) ? W : CFG_REG_WIDTH) + 2;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Saturating fixed-point helpers.
  function automatic logic signed [W-1:0] sat_mul(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] sh;
    prod = a * b;
    sh   = prod >>> F;
    if (sh[2*W-1:W-1] == '0 || sh[2*W-1:W-1] == '1) begin
      return sh[W-1:0];
    end
    return sh[2*W-1] ? MINV : MAXV;
  endfunction

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? MINV : MAXV;
    end
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) begin
      return s[W] ? MINV : MAXV;
    end
    return s[W-1:0];
  endfunction

  // Global advance: every stage moves unless a finished result is waiting.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  logic [CFG_REG_WIDTH-1:0] min_depth_q, max_depth_q, image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_depth_q    <= RST_MIN_DEPTH;
      max_depth_q    <= RST_MAX_DEPTH;
      image_width_q  <= RST_IMAGE_WIDTH;
      image_height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_DEPTH:    min_depth_q    <= cfg_data_i[CFG_REG_WIDTH-1:0];
        CFG_MAX_DEPTH:    max_depth_q    <= cfg_data_i[CFG_REG_WIDTH-1:0];
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[CFG_REG_WIDTH-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[CFG_REG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: registered input transaction.
  logic                          v0_q, op0_q;
  logic [COEF_INDEX_WIDTH-1:0]   idx0_q;
  logic signed [W-1:0]           val0_q;
  logic signed [W-1:0]           pt0_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q    <= s_axis_tuser;
      idx0_q   <= s_axis_tdata[COEF_INDEX_WIDTH-1:0];
      val0_q   <= s_axis_tdata[COEF_INDEX_WIDTH +: W];
      pt0_q[0] <= s_axis_tdata[COEF_INDEX_WIDTH + W +: W];
      pt0_q[1] <= s_axis_tdata[COEF_INDEX_WIDTH + 2*W +: W];
      pt0_q[2] <= s_axis_tdata[COEF_INDEX_WIDTH + 3*W +: W];
    end
  end

  // Pose table, written as a load leaves stage 0 so later points see it.
  logic signed [W-1:0] pose_q [POSE_ENTRIES];
  logic                pose_we;
  assign pose_we = en && v0_q && (op0_q == OP_LOAD) && (idx0_q < PROJ_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POSE_ENTRIES; i++) begin
        pose_q[i] <= '0;
      end
    end else if (pose_we) begin
      pose_q[idx0_q[3:0]] <= val0_q;
    end
  end

  // Stage 1: pose products and translation column.
  logic                        v1_q, op1_q;
  logic [COEF_INDEX_WIDTH-1:0] idx1_q;
  logic signed [W-1:0]         val1_q;
  logic signed [W-1:0]         pm1_q [9];
  logic signed [W-1:0]         pt1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= op0_q;
      idx1_q <= idx0_q;
      val1_q <= val0_q;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pm1_q[r*3+c] <= sat_mul(pose_q[r*4+c], pt0_q[c]);
        end
        pt1_q[r] <= pose_q[r*4+3];
      end
    end
  end

  // Stage 2: robot-frame point, summed column by column.
  logic                        v2_q, op2_q;
  logic [COEF_INDEX_WIDTH-1:0] idx2_q;
  logic signed [W-1:0]         val2_q;
  logic signed [W-1:0]         rob2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q  <= op1_q;
      idx2_q <= idx1_q;
      val2_q <= val1_q;
      for (int r = 0; r < 3; r++) begin
        rob2_q[r] <= sat_add(sat_add(sat_add(pm1_q[r*3], pm1_q[r*3+1]), pm1_q[r*3+2]),
                             pt1_q[r]);
      end
    end
  end

  // Projection table, written as a load leaves stage 2, where it is read.
  logic signed [W-1:0]         proj_q [PROJ_ENTRIES];
  logic                        proj_we;
  logic [COEF_INDEX_WIDTH-1:0] proj_off;
  assign proj_off = idx2_q - PROJ_BASE;
  assign proj_we  = en && v2_q && (op2_q == OP_LOAD) &&
                    (idx2_q >= PROJ_BASE) && (idx2_q < PROJ_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PROJ_ENTRIES; i++) begin
        proj_q[i] <= '0;
      end
    end else if (proj_we) begin
      proj_q[proj_off[3:0]] <= val2_q;
    end
  end

  // Stage 3: projection products; only project transactions go on from here.
  logic                v3_q;
  logic signed [W-1:0] cm3_q [12];
  logic signed [W-1:0] ct3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q && (op2_q == OP_PROJECT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          cm3_q[r*3+c] <= sat_mul(proj_q[r*4+c], rob2_q[c]);
        end
        ct3_q[r] <= proj_q[r*4+3];
      end
    end
  end

  // Stage 4: camera rows (left x, y, depth, right x).
  logic                v4_q;
  logic signed [W-1:0] cam4_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        cam4_q[r] <= sat_add(sat_add(sat_add(cm3_q[r*3], cm3_q[r*3+1]), cm3_q[r*3+2]),
                             ct3_q[r]);
      end
    end
  end

  // Stage 5: depth check and divider operands.
  logic signed [CW-1:0] z_ext, min_ext, max_ext;
  logic                 depth_rej;
  assign z_ext     = CW'(cam4_q[2]);
  assign min_ext   = CW'(min_depth_q);
  assign max_ext   = CW'(max_depth_q);
  assign depth_rej = (z_ext <= 0) || (z_ext < min_ext) || (z_ext > max_ext);

  logic                v5_q, rej5_q;
  logic signed [W-1:0] num5_q [3];
  logic        [W-1:0] den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rej5_q    <= depth_rej;
      num5_q[0] <= cam4_q[0];
      num5_q[1] <= cam4_q[1];
      num5_q[2] <= sat_sub(cam4_q[0], cam4_q[3]);
      den5_q    <= cam4_q[2];
    end
  end

  // Divider lanes for u, v and disparity.
  logic signed [W-1:0] quot [3];

  for (genvar l = 0; l < 3; l++) begin : g_div
    rspp_div_lane #(
      .DATA_WIDTH    (W),
      .FRACTION_BITS (F)
    ) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num5_q[l]),
      .den_i  (den5_q),
      .quot_o (quot[l])
    );
  end

  // Valid and reject flags travel alongside the divider stages.
  logic dv_q   [1:S];
  logic drej_q [1:S];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= S; k++) begin
        dv_q[k] <= 1'b0;
      end
    end else if (en) begin
      dv_q[1] <= v5_q;
      for (int k = 2; k <= S; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      drej_q[1] <= rej5_q;
      for (int k = 2; k <= S; k++) begin
        drej_q[k] <= drej_q[k-1];
      end
    end
  end

  // Image bounds and right-column check.
  logic signed [CW-1:0] u_ext, v_ext, w_ext, h_ext;
  logic signed [W:0]    right_col;
  logic                 in_image;
  assign u_ext     = CW'(quot[0]);
  assign v_ext     = CW'(quot[1]);
  assign w_ext     = CW'(image_width_q);
  assign h_ext     = CW'(image_height_q);
  assign right_col = {quot[0][W-1], quot[0]} - {quot[2][W-1], quot[2]};
  assign in_image  = (u_ext > 0) && (v_ext > 0) && (u_ext < w_ext) && (v_ext < h_ext) &&
                     !right_col[W];

  // Output register.
  logic                m_valid_q;
  status_e             m_status_q;
  logic signed [W-1:0] m_u_q, m_v_q, m_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= dv_q[S];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (drej_q[S]) begin
        m_status_q <= ST_DEPTH_REJECT;
        m_u_q      <= '0;
        m_v_q      <= '0;
        m_d_q      <= '0;
      end else begin
        m_status_q <= in_image ? ST_OK : ST_OUT_OF_IMAGE;
        m_u_q      <= quot[0];
        m_v_q      <= quot[1];
        m_d_q      <= quot[2];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = OUT_TW'({m_d_q, m_v_q, m_u_q});

  // Assertions.
  a_ok_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_status_q == ST_OK) |-> (m_u_q > 0) && (m_v_q > 0) && (m_u_q >= m_d_q))
    else $error("accepted result lies outside the image");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (m_status_q == ST_DEPTH_REJECT) |-> (m_u_q == 0) && (m_v_q == 0) &&
    (m_d_q == 0))
    else $error("depth reject carries nonzero fields");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(v5_q) && $stable(dv_q[S]))
    else $error("pipeline moved during a stall");

endmodule

// ----- rtl/rspp_div_lane.sv -----
// Pipelined restoring divider lane: saturated (n << F) / d, one quotient bit per stage.
module rspp_div_lane
  import rspp_pkg::*;
#(
  parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic        [DATA_WIDTH-1:0] den_i,
  output logic signed [DATA_WIDTH-1:0] quot_o
);

  localparam int W = DATA_WIDTH;
  localparam int F = FRACTION_BITS;
  localparam int S = W + F;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Per-stage state: partial remainder, dividend magnitude, divisor, quotient, flags.
  // The magnitude is only kept while later steps still shift dividend bits in.
  logic [W-1:0] rem_q [1:S-1];
  logic [W-1:0] mag_q [1:W-1];
  logic [W-1:0] den_q [1:S-1];
  logic [W-1:0] quo_q [1:S];
  logic         neg_q [1:S];
  logic         ovf_q [1:S];

  logic [W-1:0] num_mag;

  // The magnitude of the most negative value wraps onto itself, which is correct unsigned.
  assign num_mag = num_i[W-1] ? (~num_i + 1'b1) : num_i;

  for (genvar k = 0; k < S; k++) begin : g_step
    localparam int I = S - 1 - k;

    logic [W-1:0] rem_in, den_in, quo_in;
    logic         neg_in, ovf_in;
    logic         shift_bit;
    logic [W:0]   rem_sh;
    logic         fits;
    logic [W-1:0] quo_d;
    logic         ovf_d;

    // The first step takes the operands straight from the feeding stage.
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign den_in = den_i;
      assign quo_in = '0;
      assign neg_in = num_i[W-1];
      assign ovf_in = 1'b0;
    end else begin : g_next
      assign rem_in = rem_q[k];
      assign den_in = den_q[k];
      assign quo_in = quo_q[k];
      assign neg_in = neg_q[k];
      assign ovf_in = ovf_q[k];
    end

    // Dividend bit shifted in; the low F positions are the appended zeros.
    if (k == 0) begin : g_bit_first
      assign shift_bit = num_mag[I-F];
    end else if (I >= F) begin : g_bit
      assign shift_bit = mag_q[k][I-F];
    end else begin : g_zero
      assign shift_bit = 1'b0;
    end

    assign rem_sh = {rem_in, shift_bit};
    assign fits   = rem_sh >= {1'b0, den_in};

    // Quotient bits above the word only flag an overflow.
    if (I < W) begin : g_qbit
      always_comb begin
        quo_d    = quo_in;
        quo_d[I] = fits;
      end
      assign ovf_d = ovf_in;
    end else begin : g_ovf
      assign quo_d = quo_in;
      assign ovf_d = ovf_in | fits;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k+1] <= quo_d;
        neg_q[k+1] <= neg_in;
        ovf_q[k+1] <= ovf_d;
      end
    end

    // Remainder and divisor are only needed by a following step.
    if (k < S - 1) begin : g_carry
      logic [W:0]   rem_sub;
      logic [W-1:0] rem_d;
      assign rem_sub = rem_sh - {1'b0, den_in};
      assign rem_d   = fits ? rem_sub[W-1:0] : rem_sh[W-1:0];

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k+1] <= rem_d;
          den_q[k+1] <= den_in;
        end
      end
    end

    // The dividend magnitude travels on while a later step still reads it.
    if (k == 0) begin : g_mag_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mag_q[1] <= num_mag;
        end
      end
    end else if (k < W - 1) begin : g_mag_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mag_q[k+1] <= mag_q[k];
        end
      end
    end
  end

  // Apply the sign and saturate to the word range.
  always_comb begin
    if (!neg_q[S]) begin
      quot_o = (ovf_q[S] || quo_q[S][W-1]) ? MAXV : signed'(quo_q[S]);
    end else if (ovf_q[S] || (quo_q[S][W-1] && (|quo_q[S][W-2:0]))) begin
      quot_o = MINV;
    end else begin
      quot_o = signed'(~quo_q[S] + 1'b1);
    end
  end

endmodule
